// ----- hdl/x86sr_pkg.sv -----
// Package for the x86 shift/rotate flags unit: transaction structs,
// operation and operand-size codes. No dependencies.
package x86sr_pkg;

  // operation codes carried in the mode field
  localparam logic [2:0] MODE_ROL = 3'd0;
  localparam logic [2:0] MODE_ROR = 3'd1;
  localparam logic [2:0] MODE_SHL = 3'd2;
  localparam logic [2:0] MODE_SHR = 3'd3;
  localparam logic [2:0] MODE_SAR = 3'd4;

  // operand size codes
  localparam logic [1:0] WC_BYTE  = 2'd0;
  localparam logic [1:0] WC_WORD  = 2'd1;
  localparam logic [1:0] WC_DWORD = 2'd2;
  localparam logic [1:0] WC_QWORD = 2'd3;

  // count masks for qword and narrower operands
  localparam logic [7:0] CNT_MASK_Q = 8'd63;
  localparam logic [7:0] CNT_MASK_D = 8'd31;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] operand;
    logic [7:0]  count;
    logic [1:0]  width_code;
    logic        old_cf;
    logic        old_of;
    logic        old_sf;
    logic        old_zf;
    logic        old_pf;
  } x86sr_in_t;

  typedef struct packed {
    logic [63:0] result;
    logic        carry_out;
    logic        overflow_out;
    logic        sign_out;
    logic        zero_out;
    logic        parity_out;
  } x86sr_out_t;

endpackage

// ----- hdl/x86_shift_rotate_flags_unit.sv -----
// Top level of the x86 group-2 shift/rotate flags unit: input register,
// datapath, result register. Uses x86sr_pkg and x86sr_core.

// One transaction is taken on every clock at which start is high; busy is
// never raised, so a new operation can follow in the next cycle. The result
// is registered at the clock edge after the accepting edge and shown on rsp
// for exactly one cycle while done is high; it is taken at the edge that ends
// that cycle and must be captured then since the receiver cannot stall.
// The input register is followed by the result register around the
// single-pass shifter and flag logic.
module x86_shift_rotate_flags_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  x86sr_pkg::x86sr_in_t  cmd,
  output logic                  done,
  output x86sr_pkg::x86sr_out_t rsp
);

  logic                  in_vld;
  x86sr_pkg::x86sr_in_t  in_q;
  x86sr_pkg::x86sr_out_t core_out;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start & ~busy;
    end
    if (start & ~busy) begin
      in_q <= cmd;
    end
  end

  x86sr_core u_core (
    .item (in_q),
    .res  (core_out)
  );

  // result register, one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_vld;
    end
    if (in_vld) begin
      rsp <= core_out;
    end
  end

endmodule

// ----- hdl/x86sr_core.sv -----
// Combinational datapath of the shift/rotate unit: barrel shifts,
// rotates and flag generation for one transaction. Uses x86sr_pkg.
module x86sr_core (
  input  x86sr_pkg::x86sr_in_t  item,
  output x86sr_pkg::x86sr_out_t res
);

  // bit at the top of the operand width
  function automatic logic msb_of(input logic [63:0] val, input logic [1:0] wc);
    logic b;
    case (wc)
      x86sr_pkg::WC_BYTE:  b = val[7];
      x86sr_pkg::WC_WORD:  b = val[15];
      x86sr_pkg::WC_DWORD: b = val[31];
      default:             b = val[63];
    endcase
    return b;
  endfunction

  // bit just below the top of the operand width
  function automatic logic msb1_of(input logic [63:0] val, input logic [1:0] wc);
    logic b;
    case (wc)
      x86sr_pkg::WC_BYTE:  b = val[6];
      x86sr_pkg::WC_WORD:  b = val[14];
      x86sr_pkg::WC_DWORD: b = val[30];
      default:             b = val[62];
    endcase
    return b;
  endfunction

  logic [63:0]  mask;
  logic [63:0]  v;
  logic [63:0]  sx;
  logic [63:0]  rep;
  logic [5:0]   n;
  logic [5:0]   r;
  logic [127:0] dbl;
  logic [127:0] rol_w;
  logic [127:0] ror_w;
  logic [127:0] shl_w;
  logic [64:0]  shr_w;
  logic [64:0]  sar_w;
  logic [63:0]  res_v;
  logic         cf;
  logic         of;
  logic         sf;
  logic         zf;
  logic         pf;
  logic         is_one;

  // width mask, replicated pattern for rotates, sign-extended operand
  always_comb begin
    case (item.width_code)
      x86sr_pkg::WC_BYTE: begin
        mask = 64'h0000_0000_0000_00FF;
        rep  = {8{item.operand[7:0]}};
        sx   = {{56{item.operand[7]}}, item.operand[7:0]};
      end
      x86sr_pkg::WC_WORD: begin
        mask = 64'h0000_0000_0000_FFFF;
        rep  = {4{item.operand[15:0]}};
        sx   = {{48{item.operand[15]}}, item.operand[15:0]};
      end
      x86sr_pkg::WC_DWORD: begin
        mask = 64'h0000_0000_FFFF_FFFF;
        rep  = {2{item.operand[31:0]}};
        sx   = {{32{item.operand[31]}}, item.operand[31:0]};
      end
      default: begin
        mask = 64'hFFFF_FFFF_FFFF_FFFF;
        rep  = item.operand;
        sx   = item.operand;
      end
    endcase
  end

  assign v = item.operand & mask;

  // masked count, and rotate amount modulo the width
  always_comb begin
    if (item.width_code == x86sr_pkg::WC_QWORD) begin
      n = 6'(item.count & x86sr_pkg::CNT_MASK_Q);
    end else begin
      n = 6'(item.count & x86sr_pkg::CNT_MASK_D);
    end
    case (item.width_code)
      x86sr_pkg::WC_BYTE:  r = {3'b000, n[2:0]};
      x86sr_pkg::WC_WORD:  r = {2'b00, n[3:0]};
      x86sr_pkg::WC_DWORD: r = {1'b0, n[4:0]};
      default:             r = n;
    endcase
  end

  // barrel shifters; the extra low bit of the right shifts is the last bit out
  assign dbl   = {rep, rep};
  assign rol_w = dbl << r;
  assign ror_w = dbl >> r;
  assign shl_w = {64'd0, v} << n;
  assign shr_w = {v, 1'b0} >> n;
  assign sar_w = 65'($signed({sx, 1'b0}) >>> n);

  assign is_one = (n == 6'd1);

  // result and flag selection
  always_comb begin
    res_v = v;
    cf    = item.old_cf;
    of    = item.old_of;
    sf    = item.old_sf;
    zf    = item.old_zf;
    pf    = item.old_pf;
    if (n != 6'd0) begin
      case (item.mode)
        x86sr_pkg::MODE_ROL: begin
          res_v = rol_w[127:64] & mask;
          cf    = res_v[0];
          of    = is_one & (msb_of(res_v, item.width_code) ^ res_v[0]);
        end
        x86sr_pkg::MODE_ROR: begin
          res_v = ror_w[63:0] & mask;
          cf    = msb_of(res_v, item.width_code);
          of    = is_one & (msb_of(res_v, item.width_code) ^
                            msb1_of(res_v, item.width_code));
        end
        x86sr_pkg::MODE_SHL: begin
          res_v = shl_w[63:0] & mask;
          case (item.width_code)
            x86sr_pkg::WC_BYTE:  cf = shl_w[8];
            x86sr_pkg::WC_WORD:  cf = shl_w[16];
            x86sr_pkg::WC_DWORD: cf = shl_w[32];
            default:             cf = shl_w[64];
          endcase
          of    = is_one & (msb_of(res_v, item.width_code) ^ cf);
        end
        x86sr_pkg::MODE_SHR: begin
          res_v = shr_w[64:1];
          cf    = shr_w[0];
          of    = is_one & msb_of(v, item.width_code);
        end
        x86sr_pkg::MODE_SAR: begin
          res_v = sar_w[64:1] & mask;
          cf    = sar_w[0];
          of    = 1'b0;
        end
        default: begin
          res_v = v;
        end
      endcase
      // shifts update the result flags, rotates keep them
      if (item.mode == x86sr_pkg::MODE_SHL || item.mode == x86sr_pkg::MODE_SHR ||
          item.mode == x86sr_pkg::MODE_SAR) begin
        sf = msb_of(res_v, item.width_code);
        zf = (res_v == 64'd0);
        pf = ~^res_v[7:0];
      end
    end
  end

  assign res.result       = res_v;
  assign res.carry_out    = cf;
  assign res.overflow_out = of;
  assign res.sign_out     = sf;
  assign res.zero_out     = zf;
  assign res.parity_out   = pf;

endmodule
